@@ design/spom_pkg.sv @@
// Shared types and constants for the spiral-order matrix reorder block.
// No dependencies; every other design file but spom_ram imports this package.
package spom_pkg;

   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 4;
   localparam int POS_W       = 3;
   localparam int INDEX_W     = 6;
   localparam int TOTAL_W     = 7;
   localparam int BANK_COUNT  = 2;
   localparam int STORE_DEPTH = 2 ** INDEX_W;
   localparam int RAM_DEPTH   = BANK_COUNT * STORE_DEPTH;
   localparam int RAM_ADDR_W  = INDEX_W + 1;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = COUNT_W;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_COUNT    = 2'd0,
      CSR_COLUMN_COUNT = 2'd1
   } csr_reg_type;

   typedef enum logic {
      WALK_IDLE,
      WALK_RUN
   } walk_state_type;

   typedef enum logic [1:0] {
      LEG_RIGHT,
      LEG_DOWN,
      LEG_LEFT,
      LEG_UP
   } leg_type;

   // One completed matrix waiting for the spiral walk.
   typedef struct packed {
      logic [COUNT_W-1:0] rows;
      logic [COUNT_W-1:0] columns;
   } job_type;

   typedef struct packed {
      logic                  en;
      logic [RAM_ADDR_W-1:0] addr;
      logic [VALUE_W-1:0]    data;
   } ram_write_type;

   typedef struct packed {
      logic                  en;
      logic [RAM_ADDR_W-1:0] addr;
   } ram_read_type;

endpackage

@@ design/spom_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spom_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

@@ design/spom_queue.sv @@
// Two-entry job queue between loader and spiral walker; entry slot doubles
// as the storage bank of the matrix. Depends on spom_pkg.
module spom_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  spom_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output spom_pkg::job_type head_job,
   output logic              write_bank,
   output logic              read_bank
);
   import spom_pkg::*;

   job_type    job_ff [BANK_COUNT];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign empty      = (count_ff == 2'd0);
   assign head_job   = job_ff[rd_ptr_ff];
   assign write_bank = wr_ptr_ff;
   assign read_bank  = rd_ptr_ff;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         job_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ design/spom_front.sv @@
// Loader: holds the size registers, writes elements into the free bank in
// row-major order and queues a job when a matrix is complete. Uses spom_pkg.
module spom_front #(
   parameter int MAX_ROWS    = 8,
   parameter int MAX_COLUMNS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [spom_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [spom_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [spom_pkg::VALUE_W-1:0]  req_element_value,
   input  logic                                 queue_full,
   input  logic                                 write_bank,
   output logic                                 job_push,
   output spom_pkg::job_type                    job_out,
   output spom_pkg::ram_write_type              ram_write
);
   import spom_pkg::*;

   logic [COUNT_W-1:0]   row_count_ff, row_count_in;
   logic [COUNT_W-1:0]   column_count_ff, column_count_in;
   logic [INDEX_W-1:0]   load_pos_ff, load_pos_in;
   logic [COUNT_W-1:0]   rows;
   logic [COUNT_W-1:0]   columns;
   logic [2*COUNT_W-1:0] product;
   logic [TOTAL_W-1:0]   total;
   logic [INDEX_W-1:0]   pos;
   logic [TOTAL_W-1:0]   pos_next;
   logic                 accept;
   logic                 done;

   always_comb begin
      if (row_count_ff == '0) begin
         rows = COUNT_W'(1);
      end else if (row_count_ff > COUNT_W'(MAX_ROWS)) begin
         rows = COUNT_W'(MAX_ROWS);
      end else begin
         rows = row_count_ff;
      end
      if (column_count_ff == '0) begin
         columns = COUNT_W'(1);
      end else if (column_count_ff > COUNT_W'(MAX_COLUMNS)) begin
         columns = COUNT_W'(MAX_COLUMNS);
      end else begin
         columns = column_count_ff;
      end
   end

   assign product = (2*COUNT_W)'(rows) * (2*COUNT_W)'(columns);
   assign total   = product[TOTAL_W-1:0];

   // Restart the load if a size change left the position past the end.
   assign pos      = ({1'b0, load_pos_ff} >= total) ? '0 : load_pos_ff;
   assign pos_next = {1'b0, pos} + TOTAL_W'(1);
   assign done     = (pos_next == total);

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   assign ram_write.en   = accept;
   assign ram_write.addr = {write_bank, pos};
   assign ram_write.data = req_element_value;

   assign job_push        = accept && done;
   assign job_out.rows    = rows;
   assign job_out.columns = columns;

   always_comb begin
      load_pos_in = load_pos_ff;
      if (accept) begin
         load_pos_in = done ? '0 : pos_next[INDEX_W-1:0];
      end
   end

   always_comb begin
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      if (csr_write_enable) begin
         case (csr_reg_type'(csr_index))
            CSR_ROW_COUNT:    row_count_in    = csr_write_data;
            CSR_COLUMN_COUNT: column_count_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= COUNT_RESET;
         column_count_ff <= COUNT_RESET;
         load_pos_ff     <= '0;
      end else begin
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         load_pos_ff     <= load_pos_in;
      end
   end

endmodule

@@ design/spom_back.sv @@
// Spiral walker: takes queued jobs, steps the clockwise spiral one element a
// cycle unless stalled, reads the bank and presents results. Uses spom_pkg.
module spom_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           queue_empty,
   input  spom_pkg::job_type              head_job,
   input  logic                           read_bank,
   output logic                           job_pop,
   output spom_pkg::ram_read_type         ram_read,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic [spom_pkg::POS_W-1:0]     rsp_out_row,
   output logic [spom_pkg::POS_W-1:0]     rsp_out_column,
   output logic                           rsp_out_last
);
   import spom_pkg::*;

   walk_state_type     state_ff, state_in;
   leg_type            leg_ff, leg_in;
   logic [POS_W-1:0]   row_ff, row_in;
   logic [POS_W-1:0]   col_ff, col_in;
   logic [POS_W-1:0]   top_ff, top_in;
   logic [POS_W-1:0]   bottom_ff, bottom_in;
   logic [POS_W-1:0]   left_ff, left_in;
   logic [POS_W-1:0]   right_ff, right_in;
   logic [TOTAL_W-1:0] remain_ff, remain_in;
   logic [COUNT_W-1:0] columns_ff, columns_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [POS_W-1:0]   rsp_col_ff, rsp_col_in;
   logic               rsp_last_ff, rsp_last_in;

   logic                 load;
   logic                 advance;
   logic                 last;
   logic [TOTAL_W-1:0]   row_base;
   logic [TOTAL_W-1:0]   index;
   logic [2*COUNT_W-1:0] job_total;

   assign last      = (remain_ff == TOTAL_W'(1));
   assign job_total = (2*COUNT_W)'(head_job.rows) * (2*COUNT_W)'(head_job.columns);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         WALK_IDLE: if (!queue_empty) state_in = WALK_RUN;
         WALK_RUN:  if (job_pop) state_in = WALK_IDLE;
         default:   state_in = WALK_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      load    = 1'b0;
      advance = 1'b0;
      job_pop = 1'b0;
      case (state_ff)
         WALK_IDLE: load = !queue_empty;
         WALK_RUN: begin
            advance = !rsp_valid_ff || !rsp_stall;
            job_pop = advance && last;
         end
         default: ;
      endcase
   end

   assign row_base      = TOTAL_W'(row_ff) * TOTAL_W'(columns_ff);
   assign index         = row_base + TOTAL_W'(col_ff);
   assign ram_read.en   = advance;
   assign ram_read.addr = {read_bank, index[INDEX_W-1:0]};

   always_comb begin
      leg_in     = leg_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      top_in     = top_ff;
      bottom_in  = bottom_ff;
      left_in    = left_ff;
      right_in   = right_ff;
      remain_in  = remain_ff;
      columns_in = columns_ff;
      if (load) begin
         leg_in     = LEG_RIGHT;
         row_in     = '0;
         col_in     = '0;
         top_in     = '0;
         left_in    = '0;
         bottom_in  = POS_W'(head_job.rows - COUNT_W'(1));
         right_in   = POS_W'(head_job.columns - COUNT_W'(1));
         remain_in  = job_total[TOTAL_W-1:0];
         columns_in = head_job.columns;
      end else if (advance) begin
         remain_in = remain_ff - TOTAL_W'(1);
         // At the end of a leg, shrink the bound just walked and turn.
         case (leg_ff)
            LEG_RIGHT: begin
               if (col_ff == right_ff) begin
                  top_in = top_ff + POS_W'(1);
                  row_in = top_ff + POS_W'(1);
                  leg_in = LEG_DOWN;
               end else begin
                  col_in = col_ff + POS_W'(1);
               end
            end
            LEG_DOWN: begin
               if (row_ff == bottom_ff) begin
                  right_in = right_ff - POS_W'(1);
                  col_in   = right_ff - POS_W'(1);
                  leg_in   = LEG_LEFT;
               end else begin
                  row_in = row_ff + POS_W'(1);
               end
            end
            LEG_LEFT: begin
               if (col_ff == left_ff) begin
                  bottom_in = bottom_ff - POS_W'(1);
                  row_in    = bottom_ff - POS_W'(1);
                  leg_in    = LEG_UP;
               end else begin
                  col_in = col_ff - POS_W'(1);
               end
            end
            LEG_UP: begin
               if (row_ff == top_ff) begin
                  left_in = left_ff + POS_W'(1);
                  col_in  = left_ff + POS_W'(1);
                  leg_in  = LEG_RIGHT;
               end else begin
                  row_in = row_ff - POS_W'(1);
               end
            end
            default: leg_in = LEG_RIGHT;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = row_ff;
         rsp_col_in   = col_ff;
         rsp_last_in  = last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= WALK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      leg_ff      <= leg_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      top_ff      <= top_in;
      bottom_ff   <= bottom_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      remain_ff   <= remain_in;
      columns_ff  <= columns_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_column = rsp_col_ff;
   assign rsp_out_last   = rsp_last_ff;

endmodule

@@ design/spiral_order_matrix_reorder.sv @@
// Spiral-order matrix reorder: loads one element per accepted beat, then
// emits the matrix in clockwise spiral order, one result beat per cycle
// unless stalled. Throughput: 1 element in per cycle while a bank is
// free; 1 result out per cycle unless stalled, with an idle load state
// per matrix; two matrix banks. With the walker idle, a completed matrix
// is queued, loaded into the walker and read out. Reset (synchronous):
// sizes 4x4, load position 0, queue empty; no RAM clear.
module spiral_order_matrix_reorder #(
   parameter int MAX_ROWS    = 8,
   parameter int MAX_COLUMNS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [spom_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [spom_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [spom_pkg::VALUE_W-1:0]  req_element_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [spom_pkg::VALUE_W-1:0]  rsp_out_value,
   output logic [spom_pkg::POS_W-1:0]           rsp_out_row,
   output logic [spom_pkg::POS_W-1:0]           rsp_out_column,
   output logic                                 rsp_out_last
);
   import spom_pkg::*;

   logic          queue_full;
   logic          queue_empty;
   logic          write_bank;
   logic          read_bank;
   logic          job_push;
   logic          job_pop;
   job_type       job_in;
   job_type       head_job;
   ram_write_type ram_write;
   ram_read_type  ram_read;
   logic [VALUE_W-1:0] read_data;

   spom_front #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_element_value (req_element_value),
      .queue_full        (queue_full),
      .write_bank        (write_bank),
      .job_push          (job_push),
      .job_out           (job_in),
      .ram_write         (ram_write)
   );

   spom_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (job_in),
      .pop        (job_pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head_job   (head_job),
      .write_bank (write_bank),
      .read_bank  (read_bank)
   );

   spom_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock         (clock),
      .write_enable  (ram_write.en),
      .write_address (ram_write.addr),
      .write_data    (ram_write.data),
      .read_enable   (ram_read.en),
      .read_address  (ram_read.addr),
      .read_data     (read_data)
   );

   spom_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .head_job       (head_job),
      .read_bank      (read_bank),
      .job_pop        (job_pop),
      .ram_read       (ram_read),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_column (rsp_out_column),
      .rsp_out_last   (rsp_out_last)
   );

   // RAM read data is held while the result beat is stalled.
   assign rsp_out_value = read_data;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for spiral_order_matrix_reorder: loads matrices through the
// element channel and checks every spiral-order beat against a built-in predictor.
// Depends on spom_pkg and the block's RTL only.
module tb_top;
   import spom_pkg::*;

   localparam int MAX_ROWS      = 8;
   localparam int MAX_COLUMNS   = 8;
   localparam int RANDOM_ITEMS  = 120;
   localparam int QUIET_ITEMS   = 30;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 16;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam logic [VALUE_W-1:0]     VALUE_MIN   = 32'h8000_0000;
   localparam logic [VALUE_W-1:0]     VALUE_MAX   = 32'h7FFF_FFFF;

   typedef enum logic {
      STEP_CSR,
      STEP_ELEMENT
   } step_kind_type;

   // pinned: 1x1 matrix, so the beat is the element itself at (0, 0), flagged last
   typedef struct packed {
      step_kind_type         kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [COUNT_W-1:0]     data;
      logic [VALUE_W-1:0]     value;
      logic                   pinned;
   } stim_row_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   row;
      logic [POS_W-1:0]   column;
      logic               last;
   } spiral_beat_type;

   logic                               clock;
   logic                               reset;
   logic                               csr_write_enable;
   logic [CSR_INDEX_W-1:0]             csr_index;
   logic [CSR_DATA_W-1:0]              csr_write_data;
   logic                               req_valid;
   logic                               req_stall;
   logic signed [VALUE_W-1:0]          req_element_value;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic signed [VALUE_W-1:0]          rsp_out_value;
   logic [POS_W-1:0]                   rsp_out_row;
   logic [POS_W-1:0]                   rsp_out_column;
   logic                               rsp_out_last;

   // predictor state
   logic [VALUE_W-1:0]     shadow_store [MAX_ROWS*MAX_COLUMNS];
   int unsigned            shadow_fill;
   logic [COUNT_W-1:0]     shadow_rows_reg;
   logic [COUNT_W-1:0]     shadow_cols_reg;
   spiral_beat_type        pending_spiral [$];

   int                     mismatch_count = 0;
   int                     cycle_count = 0;
   bit                     pin_result = 1'b0;
   bit                     quiet_phase = 1'b0;
   bit                     idle_on = 1'b1;
   stim_row_type           directed_steps [31];

   spiral_order_matrix_reorder #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLUMNS(MAX_COLUMNS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_element_value(req_element_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_column   (rsp_out_column),
      .rsp_out_last     (rsp_out_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned clamp_count(logic [COUNT_W-1:0] raw, int unsigned limit);
      if (raw == '0) return 1;
      if (raw > limit) return limit;
      return raw;
   endfunction

   function automatic void push_spiral(int r, int c, int cols, bit last);
      spiral_beat_type beat;
      beat.value  = shadow_store[r*cols + c];
      beat.row    = POS_W'(r);
      beat.column = POS_W'(c);
      beat.last   = last;
      pending_spiral.push_back(beat);
   endfunction

   // Clockwise walk, shrinking a bound after each leg.
   function automatic void walk_spiral(int rows, int cols);
      int top, left, bottom, right, emitted, total;
      total   = rows * cols;
      emitted = 0;
      top     = 0;
      left    = 0;
      bottom  = rows - 1;
      right   = cols - 1;
      while (emitted < total) begin
         for (int i = left; i <= right && emitted < total; i++) begin
            push_spiral(top, i, cols, emitted == total - 1);
            emitted++;
         end
         top++;
         for (int i = top; i <= bottom && emitted < total; i++) begin
            push_spiral(i, right, cols, emitted == total - 1);
            emitted++;
         end
         right--;
         for (int i = right; i >= left && emitted < total; i--) begin
            push_spiral(bottom, i, cols, emitted == total - 1);
            emitted++;
         end
         bottom--;
         for (int i = bottom; i >= top && emitted < total; i--) begin
            push_spiral(i, left, cols, emitted == total - 1);
            emitted++;
         end
         left++;
      end
   endfunction

   function automatic void load_element(logic [VALUE_W-1:0] value);
      int unsigned rows, cols, total;
      rows  = clamp_count(shadow_rows_reg, MAX_ROWS);
      cols  = clamp_count(shadow_cols_reg, MAX_COLUMNS);
      total = rows * cols;
      // restart the load when a size change left the position past the end
      if (shadow_fill >= total) shadow_fill = 0;
      shadow_store[shadow_fill] = value;
      shadow_fill++;
      if (shadow_fill >= total) begin
         shadow_fill = 0;
         walk_spiral(rows, cols);
      end
   endfunction

   function automatic void apply_register(logic [CSR_INDEX_W-1:0] index,
                                          logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_ROW_COUNT: begin
            shadow_rows_reg = data;
         end
         CSR_COLUMN_COUNT: begin
            shadow_cols_reg = data;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void check_beat();
      spiral_beat_type got, want;
      got.value  = rsp_out_value;
      got.row    = rsp_out_row;
      got.column = rsp_out_column;
      got.last   = rsp_out_last;
      if (pending_spiral.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected beat: value %h row %0d column %0d last %0b",
                     got.value, got.row, got.column, got.last);
      end else begin
         want = pending_spiral.pop_front();
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("beat mismatch: got value %h row %0d column %0d last %0b, %s %h %0d %0d %0b",
                        got.value, got.row, got.column, got.last, "expected",
                        want.value, want.row, want.column, want.last);
         end
      end
   endfunction

   // Track register writes and accepted elements, then check result beats.
   always @(posedge clock) begin
      if (reset) begin
         shadow_fill     = 0;
         shadow_rows_reg = COUNT_RESET;
         shadow_cols_reg = COUNT_RESET;
      end else begin
         if (csr_write_enable) apply_register(csr_index, csr_write_data);
         if (req_valid && !req_stall) begin
            load_element(req_element_value);
            if (pin_result && pending_spiral.size() != 0) begin
               spiral_beat_type pinned_beat;
               pinned_beat.value  = req_element_value;
               pinned_beat.row    = '0;
               pinned_beat.column = '0;
               pinned_beat.last   = 1'b1;
               void'(pending_spiral.pop_back());
               pending_spiral.push_back(pinned_beat);
            end
         end
         if (rsp_valid && !rsp_stall) check_beat();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result-side backpressure: random stall bursts between random gaps, none when quiet.
   initial begin
      int run;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= 1'b0;
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 24);
         repeat (run) @(negedge clock);
         if (!quiet_phase) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 14)) @(negedge clock);
         end
      end
   end

   function automatic int pick_gap();
      if (quiet_phase || !idle_on) return 0;
      if ($urandom_range(0, 3) == 0) return $urandom_range(1, 15);
      return 0;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return '0;
         3: return '1;
         default: return $urandom();
      endcase
   endfunction

   task automatic wait_drained();
      while (pending_spiral.size() != 0) @(negedge clock);
      // let the walk and any in-flight beat settle before touching the sizes
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_element(logic [VALUE_W-1:0] value, bit pinned, int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_element_value <= value;
      pin_result = pinned;
      // hold the beat until accepted
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      int sent;
      int rows_raw, cols_raw, total, matrices;
      int phase;
      int broken;

      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_ROW_COUNT;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_element_value = '0;

      directed_steps = '{
         // partial load at the reset size of 4x4
         '{STEP_ELEMENT, '0, '0, 32'h0000_0001, 1'b0},
         '{STEP_ELEMENT, '0, '0, 32'hFFFF_FFFE, 1'b0},
         '{STEP_ELEMENT, '0, '0, 32'h1234_5678, 1'b0},
         // zero counts act as 1: the load restarts and each element is a 1x1 matrix
         '{STEP_CSR, CSR_ROW_COUNT, 4'd0, '0, 1'b0},
         '{STEP_CSR, CSR_COLUMN_COUNT, 4'd0, '0, 1'b0},
         '{STEP_ELEMENT, '0, '0, VALUE_MIN, 1'b1},
         '{STEP_ELEMENT, '0, '0, VALUE_MAX, 1'b1},
         '{STEP_ELEMENT, '0, '0, 32'h0000_0000, 1'b1},
         '{STEP_ELEMENT, '0, '0, 32'hFFFF_FFFF, 1'b1},
         // writes past the register list are dropped
         '{STEP_CSR, CSR_SPARE_A, 4'd5, '0, 1'b0},
         '{STEP_CSR, CSR_SPARE_B, 4'd15, '0, 1'b0},
         '{STEP_ELEMENT, '0, '0, 32'hA5A5_A5A5, 1'b1},
         // oversized row count saturates: 8x1 column
         '{STEP_CSR, CSR_ROW_COUNT, 4'd15, '0, 1'b0},
         '{STEP_CSR, CSR_COLUMN_COUNT, 4'd1, '0, 1'b0},
         '{STEP_ELEMENT, '0, '0, 32'h0000_0010, 1'b0},
         '{STEP_ELEMENT, '0, '0, 32'h0000_0011, 1'b0},
         '{STEP_ELEMENT, '0, '0, 32'h0000_0012, 1'b0},
         '{STEP_ELEMENT, '0, '0, 32'h0000_0013, 1'b0},
         '{STEP_ELEMENT, '0, '0, 32'h0000_0014, 1'b0},
         '{STEP_ELEMENT, '0, '0, 32'h0000_0015, 1'b0},
         '{STEP_ELEMENT, '0, '0, 32'h0000_0016, 1'b0},
         '{STEP_ELEMENT, '0, '0, 32'h0000_0017, 1'b0},
         // grow the matrix mid-load: 2x2 becomes 2x3 after two elements
         '{STEP_CSR, CSR_ROW_COUNT, 4'd2, '0, 1'b0},
         '{STEP_CSR, CSR_COLUMN_COUNT, 4'd2, '0, 1'b0},
         '{STEP_ELEMENT, '0, '0, 32'h0000_0020, 1'b0},
         '{STEP_ELEMENT, '0, '0, 32'h0000_0021, 1'b0},
         '{STEP_CSR, CSR_COLUMN_COUNT, 4'd3, '0, 1'b0},
         '{STEP_ELEMENT, '0, '0, 32'h0000_0022, 1'b0},
         '{STEP_ELEMENT, '0, '0, 32'h0000_0023, 1'b0},
         '{STEP_ELEMENT, '0, '0, 32'h0000_0024, 1'b0},
         '{STEP_ELEMENT, '0, '0, 32'h0000_0025, 1'b0}
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_steps[k]) begin
         if (directed_steps[k].kind == STEP_CSR)
            write_register(directed_steps[k].index, directed_steps[k].data);
         else
            send_element(directed_steps[k].value, directed_steps[k].pinned, pick_gap());
      end

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         quiet_phase = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
         idle_on     = ($urandom_range(0, 3) != 0);
         if (phase == 0) begin
            rows_raw = MAX_ROWS;
            cols_raw = MAX_COLUMNS;
         end else if ($urandom_range(0, 4) == 0) begin
            rows_raw = $urandom_range(0, 15);
            cols_raw = $urandom_range(0, 15);
         end else begin
            rows_raw = $urandom_range(1, 4);
            cols_raw = $urandom_range(1, 4);
         end
         if ($urandom_range(0, 1) == 0) begin
            write_register(CSR_ROW_COUNT, CSR_DATA_W'(rows_raw));
            write_register(CSR_COLUMN_COUNT, CSR_DATA_W'(cols_raw));
         end else begin
            write_register(CSR_COLUMN_COUNT, CSR_DATA_W'(cols_raw));
            write_register(CSR_ROW_COUNT, CSR_DATA_W'(rows_raw));
         end
         if ($urandom_range(0, 7) == 0)
            write_register(($urandom_range(0, 1) == 0) ? CSR_SPARE_A : CSR_SPARE_B,
                           CSR_DATA_W'($urandom_range(0, 15)));

         total    = clamp_count(CSR_DATA_W'(rows_raw), MAX_ROWS) *
                    clamp_count(CSR_DATA_W'(cols_raw), MAX_COLUMNS);
         matrices = (phase == 0) ? 1 : $urandom_range(1, 3);
         for (int m = 0; m < matrices * total && sent < RANDOM_ITEMS; m++) begin
            quiet_phase = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
            send_element(pick_value(), 1'b0, pick_gap());
            sent++;
         end
         // leave a broken matrix behind now and then; the next size change decides its fate
         if (total > 1 && $urandom_range(0, 3) == 0) begin
            broken = $urandom_range(1, total - 1);
            for (int m = 0; m < broken && sent < RANDOM_ITEMS; m++) begin
               quiet_phase = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
               send_element(pick_value(), 1'b0, pick_gap());
               sent++;
            end
         end
         phase++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_spiral.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_spiral.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
